### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, suspended while reset is low.
`define BRA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Clocked check that also holds through reset.
`define BRA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

### design/bra_pkg.sv
// Types and constants of the bump region allocator.
package bra_pkg;

  localparam int DEFAULT_ADDR_BITS = 32;
  localparam int FIELD_W = 32;
  localparam int ALIGN_W = 17;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE = 1'b1;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_REALLOC = 2'd1,
    ACT_DEALLOC = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADALIGN = 2'd1,
    ST_NOSPACE  = 2'd2
  } status_t;

  typedef struct packed {
    action_t              action;
    logic [FIELD_W-1:0]   request_size;
    logic [ALIGN_W-1:0]   alignment;
    logic [FIELD_W-1:0]   block_addr;
    logic [FIELD_W-1:0]   block_size;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [FIELD_W-1:0]   result_addr;
    logic [FIELD_W-1:0]   result_size;
    logic                 moved;
  } res_t;

endpackage

### design/bra_alloc_core.sv
// Request decode and pointer arithmetic for one allocator word.
module bra_alloc_core import bra_pkg::*; #(
  parameter int ADDR_BITS = DEFAULT_ADDR_BITS
) (
  input  req_t                 req,
  input  logic [ADDR_BITS-1:0] next_free,
  input  logic [ADDR_BITS-1:0] region_end,
  output res_t                 res_nxt,
  output logic                 nf_we,
  output logic [ADDR_BITS-1:0] nf_nxt
);

  localparam int AW = ADDR_BITS;
  localparam int CW = (AW > FIELD_W) ? AW : FIELD_W;

  logic [63:0]        baddr64, bsize64, size64, mask64, aligned64;
  logic [AW-1:0]      baddr_a, bsize_a, size_a, mask_a;
  logic [ALIGN_W-1:0] align_m1;
  logic               pow2;
  logic [AW-1:0]      pad, aligned, room_cur, room_al, room_a, last_sum;
  logic               alloc_ok, grow_ok, is_last;
  logic               do_alloc, alloc_moved;

  always_comb begin
    baddr64   = 64'(req.block_addr);
    bsize64   = 64'(req.block_size);
    size64    = 64'(req.request_size);
    align_m1  = req.alignment - ALIGN_W'(1);
    mask64    = 64'(align_m1);
    baddr_a   = baddr64[AW-1:0];
    bsize_a   = bsize64[AW-1:0];
    size_a    = size64[AW-1:0];
    mask_a    = mask64[AW-1:0];
    pow2      = (req.alignment != '0) && ((req.alignment & align_m1) == '0);

    pad       = (AW'(0) - next_free) & mask_a;
    room_cur  = region_end - next_free;
    aligned   = next_free + pad;
    room_al   = room_cur - pad;
    alloc_ok  = (next_free <= region_end) && (pad <= room_cur) &&
                (CW'(req.request_size) <= CW'(room_al));
    aligned64 = 64'(aligned);

    room_a    = region_end - baddr_a;
    grow_ok   = (baddr_a <= region_end) && (CW'(req.request_size) <= CW'(room_a));
    last_sum  = baddr_a + bsize_a;
    is_last   = (last_sum == next_free);
  end

  always_comb begin
    res_nxt     = '0;
    nf_we       = 1'b0;
    nf_nxt      = next_free;
    do_alloc    = 1'b0;
    alloc_moved = 1'b0;
    unique case (req.action)
      ACT_ALLOC, ACT_REALLOC: begin
        if (!pow2) begin
          res_nxt.status = ST_BADALIGN;
        end else if (req.action == ACT_ALLOC || req.block_addr == '0) begin
          do_alloc = 1'b1;
        end else if ((req.block_addr & FIELD_W'(align_m1)) != '0) begin
          do_alloc    = 1'b1;
          alloc_moved = 1'b1;
        end else if (!is_last) begin
          if (req.request_size <= req.block_size) begin
            res_nxt.result_addr = req.block_addr;
            res_nxt.result_size = req.request_size;
          end else begin
            do_alloc    = 1'b1;
            alloc_moved = 1'b1;
          end
        end else if (grow_ok) begin
          res_nxt.result_addr = baddr64[FIELD_W-1:0];
          res_nxt.result_size = req.request_size;
          nf_we               = 1'b1;
          nf_nxt              = baddr_a + size_a;
        end else begin
          res_nxt.status = ST_NOSPACE;
        end
        if (do_alloc) begin
          if (alloc_ok) begin
            res_nxt.result_addr = aligned64[FIELD_W-1:0];
            res_nxt.result_size = req.request_size;
            res_nxt.moved       = alloc_moved;
            nf_we               = 1'b1;
            nf_nxt              = aligned + size_a;
          end else begin
            res_nxt.status = ST_NOSPACE;
          end
        end
      end
      ACT_DEALLOC: begin
        if (is_last) begin
          nf_we  = 1'b1;
          nf_nxt = baddr_a;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### design/bump_region_allocator.sv
// Bump region allocator top level: config registers, pipeline and pointer.
//
// Usage: program region_base (index 0) and region_size (index 1) on the cfg
// port while idle; writing region_base also reloads the next-free pointer.
// Requests (alloc, realloc, dealloc) enter on the in_ valid/ready channel,
// one word per cycle while in_ready is high. Each request produces exactly
// one word on the out_ channel, in order, with status, address, size and
// the moved flag. A word accepted on in_ is registered in the input
// register, evaluated against the next-free pointer and registered in the
// output register, which drives out_. Throughput is one word per cycle
// while out_ready stays high; the next-free pointer updates in the same
// cycle its word moves to the output register, so back-to-back words
// see it at once. If the receiver holds out_ready low, the output word
// holds, the input register fills and in_ready drops until the output
// drains. Reset (synchronous, rst_n low) clears both config registers,
// the pointer and all valid flags; the region is then empty at address
// zero.
module bump_region_allocator import bra_pkg::*; #(
  parameter int ADDR_BITS = DEFAULT_ADDR_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [FIELD_W-1:0]    cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_action,
  input  logic [FIELD_W-1:0]    in_request_size,
  input  logic [ALIGN_W-1:0]    in_alignment,
  input  logic [FIELD_W-1:0]    in_block_addr,
  input  logic [FIELD_W-1:0]    in_block_size,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [FIELD_W-1:0]    out_result_addr,
  output logic [FIELD_W-1:0]    out_result_size,
  output logic                  out_moved
);

  localparam int AW = ADDR_BITS;

  logic [FIELD_W-1:0] base_r, size_r;
  logic [AW-1:0]      end_r, end_nxt, nf_r, nf_nxt;
  logic [63:0]        base64, size64, wdata64;
  logic [AW:0]        end_sum;
  logic               s1_v_r, out_v_r, s1_adv, nf_we;
  req_t               req_r;
  res_t               res_r, res_nxt;

  always_comb begin
    base64  = 64'(base_r);
    size64  = 64'(size_r);
    wdata64 = 64'(cfg_wdata);
    end_sum = {1'b0, base64[AW-1:0]} + {1'b0, size64[AW-1:0]};
    end_nxt = end_sum[AW] ? '1 : end_sum[AW-1:0];
  end

  assign s1_adv   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;

  bra_alloc_core #(.ADDR_BITS(ADDR_BITS)) u_core (
    .req        (req_r),
    .next_free  (nf_r),
    .region_end (end_r),
    .res_nxt    (res_nxt),
    .nf_we      (nf_we),
    .nf_nxt     (nf_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      size_r  <= '0;
      end_r   <= '0;
      nf_r    <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      end_r <= end_nxt;
      if (cfg_wr_en && cfg_index == REG_BASE) begin
        base_r <= cfg_wdata;
        nf_r   <= wdata64[AW-1:0];
      end else if (s1_adv && nf_we) begin
        nf_r <= nf_nxt;
      end
      if (cfg_wr_en && cfg_index == REG_SIZE) begin
        size_r <= cfg_wdata;
      end
      if (in_valid && in_ready) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r.action       <= action_t'(in_action);
      req_r.request_size <= in_request_size;
      req_r.alignment    <= in_alignment;
      req_r.block_addr   <= in_block_addr;
      req_r.block_size   <= in_block_size;
    end
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_v_r;
  assign out_status      = res_r.status;
  assign out_result_addr = res_r.result_addr;
  assign out_result_size = res_r.result_size;
  assign out_moved       = res_r.moved;

endmodule

### design/bra_checker.sv
// Port-level checks for the bump region allocator, bound to the top level.
`include "assert_macros.svh"

module bra_checker import bra_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [1:0]           out_status,
  input logic [FIELD_W-1:0]   out_result_addr,
  input logic [FIELD_W-1:0]   out_result_size,
  input logic                 out_moved
);

  // stalled output word holds
  `BRA_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_result_addr) && $stable(out_result_size) && $stable(out_moved))

  // failures carry no block
  `BRA_ASSERT(a_fail_zero, clk, rst_n, out_valid && out_status != ST_OK |-> out_result_addr == '0 && out_result_size == '0 && !out_moved)

  // a move is only reported on success
  `BRA_ASSERT(a_moved_ok, clk, rst_n, out_valid && out_moved |-> out_status == ST_OK)

  // no word right after reset
  `BRA_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid && in_ready)

endmodule

bind bump_region_allocator bra_checker u_bra_checker (.*);
